### hdl/erm_pkg.sv
// Package for the Euler rotation matrix block: widths, CORDIC constants, arctangent table.
// No dependencies.
package erm_pkg;

  localparam int ANGLE_W     = 16;
  localparam int ENTRY_W     = 16;
  localparam int CW          = 34;
  localparam int TABLE_LEN   = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TRIG_W      = 22;
  localparam int PROD_W      = 44;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV    = 34'sd652032874;
  localparam logic signed [PROD_W-1:0] OUT_MAX = 44'sd16384;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ENTRY_W-1:0] out_q14(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = (v + (44'sd1 <<< 25)) >>> 26;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < -OUT_MAX) r = -OUT_MAX;
    return r[ENTRY_W-1:0];
  endfunction

endpackage

### hdl/erm_cordic.sv
// One CORDIC lane: pipelined sine and cosine of a Q2.13 angle, results in Q.20.
// Depends on erm_pkg.
module erm_cordic #(
  parameter int STEPS = erm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [erm_pkg::ANGLE_W-1:0]  angle,
  output erm_pkg::sincos_t                    res
);
  import erm_pkg::*;

  localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 neg_r [0:N];
  logic signed [CW-1:0] za;
  logic signed [CW-1:0] z0_nxt;
  logic                 neg_nxt;

  assign za = CW'(angle) <<< 17;

  always_comb begin
    z0_nxt  = za;
    neg_nxt = 1'b0;
    if (za > HALF_PI_Q30) begin
      z0_nxt  = PI_Q30 - za;
      neg_nxt = 1'b1;
    end else if (za < -HALF_PI_Q30) begin
      z0_nxt  = -PI_Q30 - za;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= GAIN_INV;
      y_r[0]   <= '0;
      z_r[0]   <= z0_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_lut(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_lut(5'(i));
        end
      end
    end
  end

  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] cr;
  logic signed [CW-1:0] sr;
  assign xf = neg_r[N] ? -x_r[N] : x_r[N];
  assign cr = (xf + CW'(512)) >>> 10;
  assign sr = (y_r[N] + CW'(512)) >>> 10;

  always_ff @(posedge clk) begin
    if (en) begin
      res.c <= cr[TRIG_W-1:0];
      res.s <= sr[TRIG_W-1:0];
    end
  end
endmodule

### hdl/erm_merge.sv
// Merge stage: combines the three lanes' sines and cosines into the nine matrix entries.
// Depends on erm_pkg.
module erm_merge (
  input  logic                                clk,
  input  logic                                en,
  input  erm_pkg::sincos_t                    tx,
  input  erm_pkg::sincos_t                    ty,
  input  erm_pkg::sincos_t                    tz,
  output logic [9*erm_pkg::ENTRY_W-1:0]       m
);
  import erm_pkg::*;

  typedef logic signed [PROD_W-1:0] p_t;

  sincos_t tz1_r;
  trig_t   sxsy_r, cxsy_r;
  p_t      cxsz_r, sxsz_r, cxcz_r, sxcz_r, cycz_r, cysz_r, sxcy_r, cxcy_r, sy20_r;
  p_t      a_sxsy, a_cxsy;

  assign a_sxsy = (p_t'(tx.s) * p_t'(ty.s) + (p_t'(1) <<< 19)) >>> 20;
  assign a_cxsy = (p_t'(tx.c) * p_t'(ty.s) + (p_t'(1) <<< 19)) >>> 20;

  always_ff @(posedge clk) begin
    if (en) begin
      tz1_r  <= tz;
      sxsy_r <= a_sxsy[TRIG_W-1:0];
      cxsy_r <= a_cxsy[TRIG_W-1:0];
      cxsz_r <= p_t'(tx.c) * p_t'(tz.s);
      sxsz_r <= p_t'(tx.s) * p_t'(tz.s);
      cxcz_r <= p_t'(tx.c) * p_t'(tz.c);
      sxcz_r <= p_t'(tx.s) * p_t'(tz.c);
      cycz_r <= p_t'(ty.c) * p_t'(tz.c);
      cysz_r <= p_t'(ty.c) * p_t'(tz.s);
      sxcy_r <= p_t'(tx.s) * p_t'(ty.c);
      cxcy_r <= p_t'(tx.c) * p_t'(ty.c);
      sy20_r <= -(p_t'(ty.s) <<< 20);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0*ENTRY_W +: ENTRY_W] <= out_q14(cycz_r);
      m[1*ENTRY_W +: ENTRY_W] <= out_q14(p_t'(sxsy_r) * p_t'(tz1_r.c) - cxsz_r);
      m[2*ENTRY_W +: ENTRY_W] <= out_q14(p_t'(cxsy_r) * p_t'(tz1_r.c) + sxsz_r);
      m[3*ENTRY_W +: ENTRY_W] <= out_q14(cysz_r);
      m[4*ENTRY_W +: ENTRY_W] <= out_q14(p_t'(sxsy_r) * p_t'(tz1_r.s) + cxcz_r);
      m[5*ENTRY_W +: ENTRY_W] <= out_q14(p_t'(cxsy_r) * p_t'(tz1_r.s) - sxcz_r);
      m[6*ENTRY_W +: ENTRY_W] <= out_q14(sy20_r);
      m[7*ENTRY_W +: ENTRY_W] <= out_q14(sxcy_r);
      m[8*ENTRY_W +: ENTRY_W] <= out_q14(cxcy_r);
    end
  end
endmodule

### hdl/euler_rotation_matrix.sv
// Euler rotation matrix R = Rz*Ry*Rx: top level with three CORDIC lanes and a merge stage.
// Depends on erm_pkg, erm_cordic, erm_merge.
//
// Usage:
//   Input stream: in_tdata carries angle_x, angle_y, angle_z (Q2.13 radians).
//   Output stream: out_tdata carries m00..m22 (Q1.14, saturated to +-1).
//   One result per request, in order.
// Pipeline stages from input acceptance to out_tvalid: fold, one stage per
//   CORDIC step, rounding, two merge stages.
// Throughput: one request per cycle while not stalled, set by the fully pipelined CORDIC lanes.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready
//   low; in_tready then drops, and nothing is lost.
// Reset: rst_n (synchronous, active low) clears all valid bits; the
//   pipeline comes up empty and ready.
module euler_rotation_matrix #(
  parameter int CORDIC_STEPS = erm_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // angle_x[15:0], angle_y[31:16], angle_z[47:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
);
  import erm_pkg::*;

  localparam int N   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int LAT = N + 4;

  logic           en;
  logic [LAT-1:0] vld_r;
  sincos_t        tx, ty, tz;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  erm_cordic #(.STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .en(en), .angle(in_tdata[15:0]), .res(tx));
  erm_cordic #(.STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .en(en), .angle(in_tdata[31:16]), .res(ty));
  erm_cordic #(.STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .en(en), .angle(in_tdata[47:32]), .res(tz));

  erm_merge u_merge (
    .clk(clk), .en(en), .tx(tx), .ty(ty), .tz(tz), .m(out_tdata));

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("not ready with empty output");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost");
endmodule
